/* rtl/desc_pkg.sv */
// shared constants, types and helper functions for the encoder step counter
package desc_pkg;

   localparam int NUM_BUTTONS = 8;
   localparam int MASK_W      = 8;
   localparam int HIST_W      = 16;
   localparam int COUNT_LIMIT = 1023;
   localparam int CNT_W       = 10;
   localparam int STEP_W      = 3;
   localparam int PHASE_W     = 2;
   localparam int NUM_ENC     = 2;
   localparam int ENC_W       = PHASE_W * NUM_ENC;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   localparam logic [HIST_W-1:0]  PRESS_PATTERN = HIST_W'('h000F);
   localparam logic [CNT_W-1:0]   LIMIT_VALUE   = CNT_W'(COUNT_LIMIT);
   localparam logic [CNT_W:0]     LIMIT_EXT     = (CNT_W+1)'(COUNT_LIMIT);
   localparam logic [PHASE_W-1:0] PHASE_IDLE    = 2'b11;
   localparam logic [PHASE_W-1:0] PHASE_UP      = 2'b01;
   localparam logic [PHASE_W-1:0] PHASE_DOWN    = 2'b10;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [STEP_W-1:0] step;
   } mode_info_type;

   // index of the single set bit, zero when none or several are set
   function automatic logic [STEP_W-1:0] find_step(input logic [MASK_W-1:0] mask);
      logic [STEP_W-1:0] idx;
      logic [3:0]        ones;
      idx  = '0;
      ones = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (mask[i]) begin
            ones = ones + 4'd1;
            idx  = STEP_W'(i);
         end
      end
      return (ones == 4'd1) ? idx : '0;
   endfunction

   // one encoder's effect on the counter
   function automatic logic [CNT_W-1:0] apply_encoder(input logic [CNT_W-1:0]   cnt,
                                                      input logic [PHASE_W-1:0] prev,
                                                      input logic [PHASE_W-1:0] curr,
                                                      input logic [STEP_W-1:0]  step);
      logic [CNT_W:0]   sum;
      logic [CNT_W-1:0] res;
      res = cnt;
      sum = {1'b0, cnt} + (CNT_W+1)'(step);
      if (prev == PHASE_IDLE) begin
         if (curr == PHASE_UP) begin
            res = (sum >= LIMIT_EXT) ? CNT_W'(1) : sum[CNT_W-1:0];
         end else if (curr == PHASE_DOWN) begin
            res = (CNT_W'(step) > cnt) ? LIMIT_VALUE : cnt - CNT_W'(step);
         end
      end
      return res;
   endfunction

endpackage

/* rtl/desc_mode.sv */
// button press histories, toggle mask and step selection
module desc_mode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [desc_pkg::MASK_W-1:0]   button_pins_n,
   output desc_pkg::mode_info_type       mode_next
);

   logic [desc_pkg::HIST_W-1:0] hist_ff [desc_pkg::NUM_BUTTONS];
   logic [desc_pkg::HIST_W-1:0] hist_in [desc_pkg::NUM_BUTTONS];
   logic [desc_pkg::MASK_W-1:0] mask_ff;
   logic [desc_pkg::MASK_W-1:0] mask_in;
   logic                        hit;
   logic [desc_pkg::STEP_W-1:0] hit_idx;

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < desc_pkg::NUM_BUTTONS; i++) begin
         hist_in[i] = {hist_ff[i][desc_pkg::HIST_W-2:0], ~button_pins_n[i]};
         // later buttons win
         if (hist_in[i] == desc_pkg::PRESS_PATTERN) begin
            hit     = 1'b1;
            hit_idx = desc_pkg::STEP_W'(i);
         end
      end
      mask_in = mask_ff;
      if (hit) begin
         mask_in[hit_idx] = ~mask_ff[hit_idx];
      end
      mode_next.mask = mask_in;
      mode_next.step = desc_pkg::find_step(mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         for (int i = 0; i < desc_pkg::NUM_BUTTONS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (advance) begin
         mask_ff <= mask_in;
         for (int i = 0; i < desc_pkg::NUM_BUTTONS; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   a_mask_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mask_ff))
      else $error("mode mask changed without a beat");

   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      (mode_next.step != '0) |-> $onehot(mode_next.mask))
      else $error("nonzero step without a single mask bit");

endmodule

/* rtl/desc_count.sv */
// two-encoder step counter with wraparound
module desc_count (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [desc_pkg::ENC_W-1:0]   encoder_pins_n,
   input  logic [desc_pkg::STEP_W-1:0]  step,
   output logic [desc_pkg::CNT_W-1:0]   count_next
);

   logic [desc_pkg::ENC_W-1:0] phases_ff;
   logic [desc_pkg::ENC_W-1:0] phases_in;
   logic [desc_pkg::CNT_W-1:0] count_ff;
   logic [desc_pkg::CNT_W-1:0] count_mid;

   always_comb begin
      phases_in  = ~encoder_pins_n;
      // encoder one first, then encoder two on its result
      count_mid  = desc_pkg::apply_encoder(count_ff,
                                           phases_ff[desc_pkg::PHASE_W-1:0],
                                           phases_in[desc_pkg::PHASE_W-1:0], step);
      count_next = desc_pkg::apply_encoder(count_mid,
                                           phases_ff[desc_pkg::ENC_W-1:desc_pkg::PHASE_W],
                                           phases_in[desc_pkg::ENC_W-1:desc_pkg::PHASE_W],
                                           step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phases_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phases_ff <= phases_in;
         count_ff  <= count_next;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= desc_pkg::LIMIT_VALUE)
      else $error("counter above limit");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("counter moved without a beat");

endmodule

/* rtl/debounced_encoder_step_counter.sv */
// top level: input stage, mode and counter logic, result register
//
// Debounced button mode selector driving a two-encoder step counter.
// req channel: one beat per sampling tick, carrying eight active-low
// button pins and four active-low encoder phase pins.
// rsp channel: one beat per request beat, carrying the counter value,
// the toggled mode mask and the step size after that tick.
// A request beat is captured in the input stage; once the result
// register is empty or its beat is being taken, the history, mask and
// counter logic runs and the result is registered in the output stage,
// where it is valid on rsp until it is taken.
// Throughput is one beat per cycle while rsp_tready stays high, as the
// counter and mask registers update with each beat that moves on.
// While rsp_tready is low the result register holds its beat and the
// input stage can still take one more request; after that req_tready
// drops until the result is taken.
// Reset (synchronous, active high) clears all histories, the mask, the
// stored phases, the counter and both stage valid flags.
module debounced_encoder_step_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] button_pins_n, [11:8] encoder_pins_n, [15:12] zero
   input  logic [desc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] count_value, [17:10] mode_mask, [20:18] step_size, [23:21] zero
   output logic [desc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int RSP_USED_W = desc_pkg::CNT_W + desc_pkg::MASK_W + desc_pkg::STEP_W;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [desc_pkg::MASK_W-1:0]   s1_buttons_ff;
   logic [desc_pkg::ENC_W-1:0]    s1_enc_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [RSP_USED_W-1:0]         out_data_ff;
   logic                          req_fire;
   logic                          s1_go;
   desc_pkg::mode_info_type       mode_next;
   logic [desc_pkg::CNT_W-1:0]    count_next;

   assign s1_go      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   desc_mode u_mode (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_go),
      .button_pins_n (s1_buttons_ff),
      .mode_next     (mode_next)
   );

   desc_count u_count (
      .clock          (clock),
      .reset          (reset),
      .advance        (s1_go),
      .encoder_pins_n (s1_enc_ff),
      .step           (mode_next.step),
      .count_next     (count_next)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_buttons_ff <= req_tdata[desc_pkg::MASK_W-1:0];
         s1_enc_ff     <= req_tdata[desc_pkg::MASK_W +: desc_pkg::ENC_W];
      end
      if (s1_go) begin
         out_data_ff <= {mode_next.step, mode_next.mask, count_next};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(desc_pkg::RSP_DATA_W - RSP_USED_W)'(0), out_data_ff};

   a_beat_to_result: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> out_valid_ff)
      else $error("processed beat did not reach the result register");

endmodule

/* tb/tb_debounced_encoder_step_counter.sv */
// self-checking testbench for the debounced encoder step counter
module tb_debounced_encoder_step_counter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 270;
   localparam int DRAIN_CYCLES   = 10;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // packed to match rsp_tdata[20:0]
   typedef struct packed {
      logic [desc_pkg::STEP_W-1:0] step_sz;
      logic [desc_pkg::MASK_W-1:0] mask;
      logic [desc_pkg::CNT_W-1:0]  count;
   } tick_result_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [desc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [desc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   debounced_encoder_step_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // stimulus and scoreboard state
   logic [desc_pkg::ENC_W+desc_pkg::MASK_W-1:0] pending_ticks [$];
   tick_result_type         tick_expect_q [$];
   idle_mode_type           idle_mode  = IDLE_NONE;
   bit                      req_taken  = 1'b0;
   int                      queued     = 0;
   int                      accepted   = 0;
   int                      errors     = 0;
   int                      quiet_cycles = 0;

   // predictor state
   logic [desc_pkg::HIST_W-1:0] hist_model [desc_pkg::NUM_BUTTONS] = '{default: '0};
   logic [desc_pkg::MASK_W-1:0] mode_model  = '0;
   logic [desc_pkg::ENC_W-1:0]  phase_model = '0;
   int                          count_model = 0;

   // random generator state
   int                          rest_left  = 12;
   int                          press_left = 0;
   logic [desc_pkg::MASK_W-1:0] press_set  = '0;
   logic [desc_pkg::ENC_W-1:0]  last_enc_n = '0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int move_count(input int cnt,
                                     input logic [desc_pkg::PHASE_W-1:0] prev,
                                     input logic [desc_pkg::PHASE_W-1:0] curr,
                                     input int step_sz);
      int res;
      res = cnt;
      if (prev == desc_pkg::PHASE_IDLE) begin
         if (curr == desc_pkg::PHASE_UP) begin
            res = (cnt + step_sz >= desc_pkg::COUNT_LIMIT) ? 1 : cnt + step_sz;
         end else if (curr == desc_pkg::PHASE_DOWN) begin
            res = (step_sz > cnt) ? desc_pkg::COUNT_LIMIT : cnt - step_sz;
         end
      end
      return res;
   endfunction

   task automatic predict_tick(input logic [desc_pkg::MASK_W-1:0] pins_n,
                               input logic [desc_pkg::ENC_W-1:0] enc_n,
                               output tick_result_type r);
      logic [desc_pkg::ENC_W-1:0] phases;
      bit               hit;
      int               hit_idx;
      int               ones;
      int               step_sz;
      phases  = ~enc_n;
      hit     = 1'b0;
      hit_idx = 0;
      for (int i = 0; i < desc_pkg::NUM_BUTTONS; i++) begin
         hist_model[i] = {hist_model[i][desc_pkg::HIST_W-2:0], ~pins_n[i]};
         if (hist_model[i] == desc_pkg::PRESS_PATTERN) begin
            hit     = 1'b1;
            hit_idx = i;
         end
      end
      if (hit) mode_model[hit_idx] = ~mode_model[hit_idx];
      ones    = 0;
      step_sz = 0;
      for (int i = 0; i < desc_pkg::MASK_W; i++) begin
         if (mode_model[i]) begin
            ones++;
            step_sz = i;
         end
      end
      if (ones != 1) step_sz = 0;
      // encoder one first, then encoder two
      count_model = move_count(count_model, phase_model[1:0], phases[1:0], step_sz);
      count_model = move_count(count_model, phase_model[3:2], phases[3:2], step_sz);
      phase_model = phases;
      r.count   = desc_pkg::CNT_W'(count_model);
      r.mask    = mode_model;
      r.step_sz = desc_pkg::STEP_W'(step_sz);
   endtask

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 80;
         IDLE_BOTH:   return $urandom_range(99) < 16;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 80;
         IDLE_BOTH:     return $urandom_range(99) < 16;
         default:       return 1'b0;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_ticks.size() > 0 && !sender_idles()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= desc_pkg::REQ_DATA_W'(pending_ticks.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !receiver_stalls();
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      bit              beat;
      req_taken = 1'b0;
      if (!reset) begin
         beat = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            beat = 1'b1;
            got  = rsp_tdata[desc_pkg::STEP_W+desc_pkg::MASK_W+desc_pkg::CNT_W-1:0];
            if (tick_expect_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result count=%0d mask=%h step=%0d",
                        $time, got.count, got.mask, got.step_sz);
            end else begin
               want = tick_expect_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected count=%0d mask=%h step=%0d,",
                           $time, want.count, want.mask, want.step_sz,
                           " got count=%0d mask=%h step=%0d",
                           got.count, got.mask, got.step_sz);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            beat = 1'b1;
            predict_tick(req_tdata[desc_pkg::MASK_W-1:0],
                         req_tdata[desc_pkg::MASK_W+desc_pkg::ENC_W-1:desc_pkg::MASK_W], want);
            tick_expect_q.push_back(want);
            req_taken = 1'b1;
            accepted++;
         end
         quiet_cycles = beat ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     tick_expect_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic queue_tick(input logic [desc_pkg::MASK_W-1:0] pins_n,
                             input logic [desc_pkg::ENC_W-1:0] enc_n);
      pending_ticks.push_back({enc_n, pins_n});
      queued++;
   endtask

   // button press bursts after a release stretch, encoder turns out of idle, some noise
   task automatic queue_random_ticks(input int n);
      logic [desc_pkg::MASK_W-1:0] pins_n;
      logic [desc_pkg::ENC_W-1:0]  enc_n;
      int                pick;
      for (int k = 0; k < n; k++) begin
         if (press_left == 0 && rest_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               press_set = desc_pkg::MASK_W'(1) << $urandom_range(desc_pkg::MASK_W-1);
            end else if (pick < 90) begin
               press_set = (desc_pkg::MASK_W'(1) << $urandom_range(desc_pkg::MASK_W-1)) |
                           (desc_pkg::MASK_W'(1) << $urandom_range(desc_pkg::MASK_W-1));
            end else begin
               press_set = desc_pkg::MASK_W'($urandom);
            end
            press_left = $urandom_range(6, 3);
         end
         if (press_left > 0) begin
            pins_n = ~press_set;
            press_left--;
            if (press_left == 0) rest_left = $urandom_range(16, 11);
         end else begin
            pins_n = ($urandom_range(99) < 5) ? desc_pkg::MASK_W'($urandom) : '1;
            rest_left--;
         end

         if ($urandom_range(99) < 15) begin
            enc_n = desc_pkg::ENC_W'($urandom);
         end else if (last_enc_n != '0) begin
            enc_n = '0;
         end else begin
            for (int e = 0; e < desc_pkg::NUM_ENC; e++) begin
               pick = $urandom_range(99);
               // pins are active low: 10 turns up, 01 turns down
               enc_n[e*desc_pkg::PHASE_W +: desc_pkg::PHASE_W] =
                  (pick < 40) ? ~desc_pkg::PHASE_UP :
                  (pick < 80) ? ~desc_pkg::PHASE_DOWN : ~desc_pkg::PHASE_IDLE;
            end
         end
         last_enc_n = enc_n;
         queue_tick(pins_n, enc_n);
      end
   endtask

   task automatic wait_drained();
      while (accepted != queued || tick_expect_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, starting from reset state
      queue_tick(8'hFF, 4'h0);
      queue_tick(8'hFF, 4'h2);                 // up with zero step
      queue_tick(8'hFF, 4'h0);
      queue_tick(8'hFF, 4'h1);                 // down with zero step at zero
      repeat (4) queue_tick(8'hF7, 4'h0);      // button 3 toggles on the fourth tick
      queue_tick(8'hF7, 4'h1);                 // down below zero wraps to the limit
      queue_tick(8'hFF, 4'h0);
      queue_tick(8'hFF, 4'h8);                 // encoder two up at the limit wraps to one
      queue_tick(8'hFF, 4'h0);
      queue_tick(8'hFF, 4'h4);                 // encoder two down wraps
      queue_tick(8'hFF, 4'h0);
      queue_tick(8'hFF, 4'hA);                 // both encoders up in one tick
      queue_tick(8'hFF, 4'h0);
      repeat (4) queue_tick(8'hFC, 4'h0);      // two buttons match together, highest wins
      queue_tick(8'hFC, 4'h1);                 // several mask bits set, zero step
      queue_tick(8'h00, 4'hF);
      queue_tick(8'hFF, 4'h5);
      queue_tick(8'h00, 4'h0);
      wait_drained();

      idle_mode = IDLE_NONE;
      queue_random_ticks(PHASE_ITEMS);
      wait_drained();
      idle_mode = IDLE_SENDER;
      queue_random_ticks(PHASE_ITEMS);
      wait_drained();
      idle_mode = IDLE_RECEIVER;
      queue_random_ticks(PHASE_ITEMS);
      wait_drained();
      idle_mode = IDLE_BOTH;
      queue_random_ticks(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tick_expect_q.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $time, tick_expect_q.size());
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/desc_pkg.sv
rtl/desc_mode.sv
rtl/desc_count.sv
rtl/debounced_encoder_step_counter.sv
tb/tb_debounced_encoder_step_counter.sv
